### rtl/tpc_pkg.sv
// Shared types and constants for the text pre-tokenizer chunk marker.
// No dependencies; imported by the core, the output queue and the top level.
`default_nettype none

package tpc_pkg;

   localparam int BYTE_W     = 8;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = FIFO_AW + 1;

   // byte classes
   localparam logic [BYTE_W-1:0] CHAR_APOS  = 8'h27;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_LC_A  = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LC_Z  = 8'h7A;
   localparam logic [BYTE_W-1:0] CHAR_UC_A  = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_LC_S  = 8'h73;
   localparam logic [BYTE_W-1:0] CHAR_LC_T  = 8'h74;
   localparam logic [BYTE_W-1:0] CHAR_LC_M  = 8'h6D;
   localparam logic [BYTE_W-1:0] CHAR_LC_D  = 8'h64;
   localparam logic [BYTE_W-1:0] CHAR_LC_R  = 8'h72;
   localparam logic [BYTE_W-1:0] CHAR_LC_V  = 8'h76;
   localparam logic [BYTE_W-1:0] CHAR_LC_L  = 8'h6C;
   localparam logic [BYTE_W-1:0] CHAR_LC_E  = 8'h65;
   localparam logic [BYTE_W-1:0] CASE_DIFF  = 8'h20;
   localparam logic [BYTE_W-1:0] HIGH_BYTE  = 8'd128;

   // UTF-8 lead byte masks
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'hF0;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              chunk_start;
      logic              out_last;
   } rsp_item_type;

   // up to two result items per accepted input item, in order
   typedef struct packed {
      logic         en0;
      rsp_item_type item0;
      logic         en1;
      rsp_item_type item1;
   } push_type;

endpackage

`default_nettype wire

### rtl/tpc_req_if.sv
// Input channel: one text byte per item with its end-of-text flag.
// No dependencies.
`default_nettype none

interface tpc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

### rtl/tpc_rsp_if.sv
// Result channel: one text byte per item with its chunk-start and last flags.
// No dependencies.
`default_nettype none

interface tpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       chunk_start;
   logic       out_last;

   modport source (output valid, output out_byte, output chunk_start, output out_last,
                   input ready);
   modport sink   (input valid, input out_byte, input chunk_start, input out_last,
                   output ready);
endinterface

`default_nettype wire

### rtl/text_pretokenizer_chunker_top.sv
// Pre-token chunk marker for a byte stream. Each byte comes back out one item
// later with chunk_start set when it opens a new chunk (contraction, letter or
// UTF-8 run, digit run, space-led run, whitespace run, or a single byte). One
// byte is held back as lookahead, so a byte leaves when the next one arrives;
// the byte flagged in_last flushes any held byte and itself (up to two result items).
// A byte is taken every cycle while req_chan.ready is high; the decision and the
// held-byte register form one stage; results drain through a four-entry queue at
// one item per cycle while rsp_chan.ready is high. req_chan.ready drops while that queue holds more than two items.
// Depends on tpc_pkg, tpc_req_if, tpc_rsp_if, tpc_core and tpc_out_fifo.
`default_nettype none

module text_pretokenizer_chunker_top import tpc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   tpc_req_if.sink   req_chan,
   tpc_rsp_if.source rsp_chan
);

   push_type push;
   logic     room;

   tpc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .room     (room),
      .push     (push)
   );

   tpc_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

### rtl/tpc_core.sv
// Chunk decision core: holds one byte back and classifies it against the next.
// Depends on tpc_pkg and tpc_req_if; feeds tpc_out_fifo through a push_type.
`default_nettype none

module tpc_core import tpc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   tpc_req_if.sink    req_chan,
   input  wire logic  room,
   output push_type   push
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_LETTERS,
      MODE_DIGITS,
      MODE_SPACES,
      MODE_PENDING,
      MODE_TAIL
   } mode_type;

   typedef struct packed {
      logic     start;
      mode_type mode;
      logic [1:0] absorb;
   } dec_type;

   function automatic logic is_letter(logic [BYTE_W-1:0] b);
      return (b >= CHAR_LC_A && b <= CHAR_LC_Z) || (b >= CHAR_UC_A && b <= CHAR_UC_Z) ||
             (b >= HIGH_BYTE);
   endfunction

   function automatic logic is_digit(logic [BYTE_W-1:0] b);
      return b >= CHAR_0 && b <= CHAR_9;
   endfunction

   function automatic logic is_ws(logic [BYTE_W-1:0] b);
      return b == CHAR_SPACE || b == CHAR_LF || b == CHAR_CR || b == CHAR_TAB;
   endfunction

   function automatic logic [BYTE_W-1:0] to_lower(logic [BYTE_W-1:0] b);
      return (b >= CHAR_UC_A && b <= CHAR_UC_Z) ? b + CASE_DIFF : b;
   endfunction

   function automatic logic [1:0] owed_after(logic [BYTE_W-1:0] b);
      logic [1:0] n;
      priority if ((b & LEAD2_MASK) == LEAD2_VAL) n = 2'd1;
      else if ((b & LEAD3_MASK) == LEAD3_VAL)     n = 2'd2;
      else if ((b & LEAD4_MASK) == LEAD4_VAL)     n = 2'd3;
      else                                        n = 2'd0;
      return n;
   endfunction

   function automatic dec_type decide(mode_type mode, logic [1:0] absorb,
                                      logic [BYTE_W-1:0] b, logic has_next,
                                      logic [BYTE_W-1:0] nx);
      logic [BYTE_W-1:0] lx;
      dec_type d;
      lx       = to_lower(nx);
      d.start  = 1'b0;
      d.mode   = mode;
      d.absorb = absorb;
      priority if (mode == MODE_LETTERS && absorb != 2'd0) begin
         d.absorb = absorb - 2'd1;
      end else if (mode == MODE_TAIL) begin
         d.mode = MODE_IDLE;
      end else if (mode == MODE_PENDING && has_next && (lx == CHAR_LC_E || lx == CHAR_LC_L)) begin
         d.mode = MODE_TAIL;
      end else if (mode == MODE_LETTERS && is_letter(b)) begin
         d.absorb = owed_after(b);
      end else if (mode == MODE_DIGITS && is_digit(b)) begin
         d.start = 1'b0;
      end else if (mode == MODE_SPACES && is_ws(b)) begin
         d.start = 1'b0;
      end else begin
         d.start  = 1'b1;
         d.absorb = 2'd0;
         priority if (b == CHAR_APOS) begin
            if (has_next && (lx == CHAR_LC_S || lx == CHAR_LC_T ||
                             lx == CHAR_LC_M || lx == CHAR_LC_D)) begin
               d.mode = MODE_TAIL;
            end else if (has_next && (lx == CHAR_LC_R || lx == CHAR_LC_V ||
                                      lx == CHAR_LC_L)) begin
               d.mode = MODE_PENDING;
            end else begin
               d.mode = MODE_IDLE;
            end
         end else if (is_letter(b)) begin
            d.mode   = MODE_LETTERS;
            d.absorb = owed_after(b);
         end else if (is_digit(b)) begin
            d.mode = MODE_DIGITS;
         end else if (b == CHAR_SPACE && has_next && is_letter(nx)) begin
            d.mode = MODE_LETTERS;
         end else if (b == CHAR_SPACE && has_next && is_digit(nx)) begin
            d.mode = MODE_DIGITS;
         end else if (is_ws(b)) begin
            d.mode = MODE_SPACES;
         end else begin
            d.mode = MODE_IDLE;
         end
      end
      return d;
   endfunction

   logic [BYTE_W-1:0] held_byte_ff, held_byte_in;
   logic              held_valid_ff, held_valid_in;
   mode_type          mode_ff, mode_in;
   logic [1:0]        absorb_ff, absorb_in;

   logic    fire;
   dec_type dec_held;
   dec_type dec_last;
   dec_type mid;

   assign req_chan.ready = room;
   assign fire = req_chan.valid && room;

   always_comb begin
      dec_held = decide(mode_ff, absorb_ff, held_byte_ff, 1'b1, req_chan.in_byte);
      mid      = held_valid_ff ? dec_held : dec_type'{1'b0, mode_ff, absorb_ff};
      // the final byte is decided with no lookahead, after the held byte
      dec_last = decide(mid.mode, mid.absorb, req_chan.in_byte, 1'b0, '0);

      push.en0   = fire && held_valid_ff;
      push.item0 = '{out_byte: held_byte_ff, chunk_start: dec_held.start, out_last: 1'b0};
      push.en1   = fire && req_chan.in_last;
      push.item1 = '{out_byte: req_chan.in_byte, chunk_start: dec_last.start, out_last: 1'b1};

      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      mode_in       = mode_ff;
      absorb_in     = absorb_ff;
      if (fire) begin
         if (req_chan.in_last) begin
            held_valid_in = 1'b0;
            mode_in       = MODE_IDLE;
            absorb_in     = 2'd0;
         end else begin
            held_byte_in  = req_chan.in_byte;
            held_valid_in = 1'b1;
            mode_in       = mid.mode;
            absorb_in     = mid.absorb;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         mode_ff       <= MODE_IDLE;
         absorb_ff     <= 2'd0;
      end else begin
         held_valid_ff <= held_valid_in;
         mode_ff       <= mode_in;
         absorb_ff     <= absorb_in;
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
   end

endmodule

`default_nettype wire

### rtl/tpc_out_fifo.sv
// Output queue: takes up to two result items a cycle, delivers one a cycle while rsp_chan.ready is high.
// Depends on tpc_pkg and tpc_rsp_if.
`default_nettype none

module tpc_out_fifo import tpc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire push_type push,
   output logic       room,
   tpc_rsp_if.source  rsp_chan
);

   rsp_item_type mem_ff [FIFO_DEPTH];

   logic [FIFO_AW-1:0] wr_ff, wr_in;
   logic [FIFO_AW-1:0] rd_ff, rd_in;
   logic [FIFO_CW-1:0] count_ff, count_in;
   logic [1:0]         n_push;
   logic               pop;

   // two free slots are always kept for the final byte of a text
   assign room = count_ff <= FIFO_CW'(FIFO_DEPTH - 2);

   assign rsp_chan.valid       = count_ff != '0;
   assign rsp_chan.out_byte    = mem_ff[rd_ff].out_byte;
   assign rsp_chan.chunk_start = mem_ff[rd_ff].chunk_start;
   assign rsp_chan.out_last    = mem_ff[rd_ff].out_last;

   always_comb begin
      pop      = rsp_chan.valid && rsp_chan.ready;
      n_push   = {1'b0, push.en0} + {1'b0, push.en1};
      wr_in    = wr_ff + FIFO_AW'(n_push);
      rd_in    = rd_ff + FIFO_AW'(pop);
      count_in = count_ff + FIFO_CW'(n_push) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.en0 && push.en1) begin
         mem_ff[wr_ff]                <= push.item0;
         mem_ff[wr_ff + FIFO_AW'(1)]  <= push.item1;
      end else if (push.en0) begin
         mem_ff[wr_ff] <= push.item0;
      end else if (push.en1) begin
         mem_ff[wr_ff] <= push.item1;
      end
   end

endmodule

`default_nettype wire
